// ===== sv/rtle_pkg.sv =====
package rtle_pkg;

    localparam int ADDR_W   = 32;
    localparam int OP_W     = 2;
    localparam int IDX_W    = 5;
    localparam int STAT_W   = 3;
    localparam int LEN_W    = 6;
    localparam int FILL_W   = 6;
    localparam int IN_DW    = 136;
    localparam int OUT_DW   = 48;

    localparam logic [ADDR_W-1:0] ALL_ONES = 32'hffff_ffff;

    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_NO_ROUTE  = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STAT_W-1:0] ST_DUPLICATE = 3'd3;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd4;
    localparam logic [STAT_W-1:0] ST_BAD_INDEX = 3'd5;

    // One stored route: mask, destination net, next hop and mask length (ones in the mask)
    typedef struct packed {
        logic [ADDR_W-1:0] mask;
        logic [ADDR_W-1:0] dest;
        logic [ADDR_W-1:0] hop;
        logic [LEN_W-1:0]  len;
    } route_t;

    // Item walking the chain, with the running best match
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] mask;
        logic [ADDR_W-1:0] dest;
        logic [ADDR_W-1:0] hop;
        logic [IDX_W-1:0]  idx;
        logic              found;
        logic [LEN_W-1:0]  best_len;
        logic [ADDR_W-1:0] best_hop;
        logic              dup;
    } token_t;

    // Per-cell control from the top level
    typedef struct packed {
        logic live;
        logic wr;
        logic sh;
    } cell_ctl_t;

    function automatic logic [3:0] ones_in_byte(input logic [7:0] b);
        logic [3:0] n;
        n = 4'd0;
        for (int k = 0; k < 8; k++)
        begin
            n = n + {3'd0, b[k]};
        end
        return n;
    endfunction

    function automatic logic [LEN_W-1:0] ones_in(input logic [ADDR_W-1:0] v);
        logic [LEN_W-1:0] lo;
        logic [LEN_W-1:0] hi;
        lo = {2'd0, ones_in_byte(v[7:0])} + {2'd0, ones_in_byte(v[15:8])};
        hi = {2'd0, ones_in_byte(v[23:16])} + {2'd0, ones_in_byte(v[31:24])};
        return lo + hi;
    endfunction

endpackage

// ===== sv/rtle_cell.sv =====
module rtle_cell
    import rtle_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  cell_ctl_t ctl,
    input  route_t    wr_entry,
    input  route_t    nbr_entry,
    output route_t    entry,
    input  logic      tok_vld_in,
    input  token_t    tok_in,
    output logic      tok_vld_out,
    output token_t    tok_out
);

    route_t entry_reg;
    route_t entry_next;
    logic   tok_vld_reg;
    token_t tok_reg;
    token_t tok_next;
    logic   match;
    logic   dup;

    // Compare the passing item against the stored route
    always_comb
    begin
        match = ctl.live && ((entry_reg.mask & tok_in.addr) == entry_reg.dest);
        dup   = ctl.live && (entry_reg.mask == tok_in.mask)
                && (entry_reg.dest == tok_in.dest) && (entry_reg.hop == tok_in.hop);
        tok_next = tok_in;
        // later route wins a tie in length
        if (match && (!tok_in.found || entry_reg.len >= tok_in.best_len))
        begin
            tok_next.found    = 1'b1;
            tok_next.best_len = entry_reg.len;
            tok_next.best_hop = entry_reg.hop;
        end
        if (dup)
        begin
            tok_next.dup = 1'b1;
        end
    end

    always_comb
    begin
        if (ctl.wr)
        begin
            entry_next = wr_entry;
        end
        else if (ctl.sh)
        begin
            entry_next = nbr_entry;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        if (en)
        begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            tok_vld_reg <= tok_vld_in;
        end
    end

    assign entry       = entry_reg;
    assign tok_vld_out = tok_vld_reg;
    assign tok_out     = tok_reg;

endmodule

// ===== sv/route_table_lookup_engine.sv =====
// Channel | Direction | Handshake          | Payload
// s_*     | in        | s_tvalid, s_tready | s_tdata: opcode, lookup address, mask, dest, hop, index
// m_*     | out       | m_tvalid, m_tready | m_tdata: status, next hop, fill count
//
// Flow: an item walks the row of cells, one cell per cycle, and its result is
// registered for m_* as it leaves the last cell; a new item is not taken until
// the previous one has left the row.
// Reset clears the fill count and the valid bits; route storage is not cleared,
// as only entries below the fill count are ever read.
// A result held by a stalled m_tready freezes the row and holds off s_tready.
module route_table_lookup_engine
    import rtle_pkg::*;
#(
    parameter int TABLE_DEPTH = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    // [1:0] opcode, [33:2] lookup_address, [65:34] entry_mask,
    // [97:66] entry dest net, [129:98] entry_next_hop, [134:130] entry_index
    input  logic [IN_DW-1:0]  s_tdata,
    output logic              m_tvalid,
    input  logic              m_tready,
    // [2:0] status, [34:3] next_hop, [40:35] fill_count
    output logic [OUT_DW-1:0] m_tdata
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W = (CNT_W > FILL_W) ? CNT_W : FILL_W;

    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              busy_reg;
    logic              busy_next;
    logic              out_vld_reg;
    logic              out_vld_next;
    logic [OUT_DW-1:0] out_data_reg;
    logic [OUT_DW-1:0] out_data_next;

    logic              tok_vld [TABLE_DEPTH+1];
    token_t            tok     [TABLE_DEPTH+1];
    route_t            entries [TABLE_DEPTH];
    cell_ctl_t         ctl     [TABLE_DEPTH];
    route_t            new_entry;

    logic              en;
    logic              exit_item;
    token_t            ex;
    logic              do_wr;
    logic              do_del;
    logic [STAT_W-1:0] res_status;
    logic [ADDR_W-1:0] res_hop;
    logic [CMP_W-1:0]  cnt_cmp;
    logic [CMP_W-1:0]  idx_cmp;
    logic [CMP_W-1:0]  fill_ext;

    assign s_tready = !busy_reg;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

    // Freeze the row while a finished item waits on a full output register
    assign en        = !(tok_vld[TABLE_DEPTH] && out_vld_reg && !m_tready);
    assign exit_item = tok_vld[TABLE_DEPTH] && en;
    assign ex        = tok[TABLE_DEPTH];

    // Build the entering item from the input fields
    assign tok_vld[0] = s_tvalid && s_tready;
    assign tok[0]     = '{op:       s_tdata[1:0],
                          addr:     s_tdata[33:2],
                          mask:     s_tdata[65:34],
                          dest:     s_tdata[97:66],
                          hop:      s_tdata[129:98],
                          idx:      s_tdata[134:130],
                          found:    1'b0,
                          best_len: '0,
                          best_hop: '0,
                          dup:      1'b0};

    assign new_entry.mask = ex.mask;
    assign new_entry.dest = ex.dest;
    assign new_entry.hop  = ex.hop;
    assign new_entry.len  = ones_in(ex.mask);

    assign cnt_cmp = CMP_W'(cnt_reg);
    assign idx_cmp = CMP_W'(ex.idx);

    // Decide the outcome as the item leaves the last cell
    always_comb
    begin
        res_status = ST_OK;
        res_hop    = '0;
        do_wr      = 1'b0;
        do_del     = 1'b0;
        cnt_next   = cnt_reg;
        case (ex.op)
            OP_LOOKUP:
            begin
                if (ex.found)
                begin
                    res_hop = (ex.best_hop == '0) ? ex.addr : ex.best_hop;
                end
                else
                begin
                    res_status = ST_NO_ROUTE;
                    res_hop    = ALL_ONES;
                end
            end
            OP_ADD:
            begin
                if (cnt_cmp >= CMP_W'(TABLE_DEPTH))
                begin
                    res_status = ST_FULL;
                end
                else if (ex.dup)
                begin
                    res_status = ST_DUPLICATE;
                end
                else
                begin
                    do_wr    = exit_item;
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            OP_DELETE:
            begin
                if (cnt_reg == '0)
                begin
                    res_status = ST_EMPTY;
                end
                else if (idx_cmp >= cnt_cmp)
                begin
                    res_status = ST_BAD_INDEX;
                end
                else
                begin
                    do_del   = exit_item;
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            default:
            begin
                res_status = ST_OK;
            end
        endcase
    end

    assign fill_ext = CMP_W'(cnt_next);

    always_comb
    begin
        busy_next     = busy_reg;
        out_vld_next  = out_vld_reg;
        out_data_next = out_data_reg;
        if (out_vld_reg && m_tready)
        begin
            out_vld_next = 1'b0;
        end
        if (tok_vld[0])
        begin
            busy_next = 1'b1;
        end
        if (exit_item)
        begin
            busy_next     = 1'b0;
            out_vld_next  = 1'b1;
            out_data_next = {7'd0, fill_ext[FILL_W-1:0], res_hop, res_status};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            busy_reg    <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            busy_reg    <= busy_next;
            out_vld_reg <= out_vld_next;
            if (exit_item)
            begin
                cnt_reg <= cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    // Row of cells; on delete each cell from the index up takes its upper neighbour
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        localparam logic [CMP_W-1:0] POS  = CMP_W'(i);
        localparam logic [CMP_W-1:0] POS1 = CMP_W'(i + 1);

        route_t nbr;

        always_comb
        begin
            ctl[i].live = POS < cnt_cmp;
            ctl[i].wr   = do_wr && (POS == cnt_cmp);
            ctl[i].sh   = do_del && (POS >= idx_cmp) && (POS1 < cnt_cmp);
        end

        if (i == TABLE_DEPTH - 1)
        begin : g_top
            assign nbr = entries[i];
        end
        else
        begin : g_mid
            assign nbr = entries[i+1];
        end

        rtle_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .en          (en),
            .ctl         (ctl[i]),
            .wr_entry    (new_entry),
            .nbr_entry   (nbr),
            .entry       (entries[i]),
            .tok_vld_in  (tok_vld[i]),
            .tok_in      (tok[i]),
            .tok_vld_out (tok_vld[i+1]),
            .tok_out     (tok[i+1])
        );
    end

endmodule

// ===== bench/route_table_lookup_engine_test.sv =====
`timescale 1ns / 1ps

module route_table_lookup_engine_test;

    import rtle_pkg::*;

    localparam int TABLE_DEPTH      = 32;
    localparam int IDLE_PERCENT     = 22;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT      = 400_000;

    // The fourth opcode is not decoded by the block; it must leave the table alone
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] mask;
        logic [ADDR_W-1:0] dest;
        logic [ADDR_W-1:0] hop;
        logic [IDX_W-1:0]  idx;
    } route_cmd_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ADDR_W-1:0] hop;
        logic [FILL_W-1:0] fill;
    } route_reply_t;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [IN_DW-1:0]  s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_DW-1:0] m_tdata;

    // Shadow copy of the routing table, updated as each item is accepted
    logic [ADDR_W-1:0] route_mask [TABLE_DEPTH];
    logic [ADDR_W-1:0] route_dest [TABLE_DEPTH];
    logic [ADDR_W-1:0] route_hop  [TABLE_DEPTH];
    int unsigned       route_count;

    // Replies still owed by the block, oldest first
    route_reply_t      pending_replies [$];

    int  fail_count;
    int  replies_seen;
    int  cycle_count;
    bit  steady;            // no idling on either side while set
    bit  long_hold_request; // receiver picks this up and stalls for a long stretch
    bit  grow_phase;        // random traffic favours adds while set, deletes otherwise

    route_table_lookup_engine #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop: a hung handshake must not leave the run spinning
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction: apply one command to the shadow table and return the
    // reply the block must give. Lookup takes the longest mask among the
    // matching routes, the later route on a tie; a zero hop means the route
    // is directly connected and the address itself comes back.
    // ------------------------------------------------------------------
    function automatic route_reply_t predict_reply(input route_cmd_t c);
        route_reply_t      r;
        bit                found;
        bit                dup;
        int                best_len;
        logic [ADDR_W-1:0] best_hop;
        found    = 1'b0;
        dup      = 1'b0;
        best_len = 0;
        best_hop = '0;
        r.status = ST_OK;
        r.hop    = '0;
        case (c.op)
            OP_LOOKUP:
            begin
                for (int i = 0; i < route_count; i++)
                begin
                    if ((route_mask[i] & c.addr) == route_dest[i]
                        && (!found || $countones(route_mask[i]) >= best_len))
                    begin
                        found    = 1'b1;
                        best_len = $countones(route_mask[i]);
                        best_hop = route_hop[i];
                    end
                end
                if (!found)
                begin
                    r.status = ST_NO_ROUTE;
                    r.hop    = ALL_ONES;
                end
                else
                begin
                    r.hop = (best_hop == '0) ? c.addr : best_hop;
                end
            end
            OP_ADD:
            begin
                // Full takes precedence over duplicate
                if (route_count >= TABLE_DEPTH)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    for (int i = 0; i < route_count; i++)
                    begin
                        if (route_mask[i] == c.mask && route_dest[i] == c.dest
                            && route_hop[i] == c.hop)
                        begin
                            dup = 1'b1;
                        end
                    end
                    if (dup)
                    begin
                        r.status = ST_DUPLICATE;
                    end
                    else
                    begin
                        route_mask[route_count] = c.mask;
                        route_dest[route_count] = c.dest;
                        route_hop[route_count]  = c.hop;
                        route_count++;
                    end
                end
            end
            OP_DELETE:
            begin
                if (route_count == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else if (c.idx >= route_count)
                begin
                    r.status = ST_BAD_INDEX;
                end
                else
                begin
                    // Close the gap: later routes move down one place
                    for (int i = c.idx; i + 1 < route_count; i++)
                    begin
                        route_mask[i] = route_mask[i + 1];
                        route_dest[i] = route_dest[i + 1];
                        route_hop[i]  = route_hop[i + 1];
                    end
                    route_count--;
                end
            end
            default:
            begin
            end
        endcase
        r.fill = FILL_W'(route_count);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    task automatic send_item(input route_cmd_t c);
        @(negedge clk);
        while (!steady && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {1'b0, c.idx, c.hop, c.dest, c.mask, c.addr, c.op};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        // Accepted at this edge: record what the block owes for it
        pending_replies.push_back(predict_reply(c));
    endtask

    // Drop valid and hold off until every owed reply has arrived
    task automatic settle_replies();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending_replies.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Unused fields carry random filler so that stale bits cannot hide
    function automatic route_cmd_t filler_cmd(input logic [OP_W-1:0] op);
        route_cmd_t c;
        c.op   = op;
        c.addr = $urandom;
        c.mask = $urandom;
        c.dest = $urandom;
        c.hop  = $urandom;
        c.idx  = IDX_W'($urandom);
        return c;
    endfunction

    task automatic add_route(input logic [ADDR_W-1:0] mask, input logic [ADDR_W-1:0] dest,
                             input logic [ADDR_W-1:0] hop);
        route_cmd_t c;
        c      = filler_cmd(OP_ADD);
        c.mask = mask;
        c.dest = dest;
        c.hop  = hop;
        send_item(c);
    endtask

    task automatic lookup_route(input logic [ADDR_W-1:0] addr);
        route_cmd_t c;
        c      = filler_cmd(OP_LOOKUP);
        c.addr = addr;
        send_item(c);
    endtask

    task automatic delete_route(input logic [IDX_W-1:0] idx);
        route_cmd_t c;
        c     = filler_cmd(OP_DELETE);
        c.idx = idx;
        send_item(c);
    endtask

    // Prefix-style route inside a small cluster of first octets, so that
    // random routes overlap and compete for the longest match
    function automatic route_cmd_t clustered_route();
        route_cmd_t c;
        c      = filler_cmd(OP_ADD);
        c.mask = ALL_ONES << (ADDR_W - $urandom_range(0, ADDR_W));
        c.dest = {8'($urandom_range(10, 13)), 24'($urandom)} & c.mask;
        c.hop  = ($urandom_range(0, 99) < 15) ? '0 : ADDR_W'($urandom);
        return c;
    endfunction

    function automatic route_cmd_t random_cmd();
        route_cmd_t c;
        int         pick;
        int         style;
        int         add_share;
        int         del_share;
        int         k;
        c         = filler_cmd(OP_LOOKUP);
        pick      = $urandom_range(0, 99);
        add_share = grow_phase ? 45 : 10;
        del_share = grow_phase ? 10 : 45;
        if (pick < 2)
        begin
            c.op = OP_SPARE;
        end
        else if (pick < 2 + add_share)
        begin
            style = $urandom_range(0, 99);
            if (style < 10 && route_count > 0)
            begin
                // Re-offer a stored route unchanged
                k      = $urandom_range(0, route_count - 1);
                c.mask = route_mask[k];
                c.dest = route_dest[k];
                c.hop  = route_hop[k];
            end
            else if (style < 90)
            begin
                c = clustered_route();
            end
            c.op = OP_ADD;
        end
        else if (pick < 2 + add_share + del_share)
        begin
            c.op = OP_DELETE;
            if (route_count > 0 && $urandom_range(0, 99) < 85)
            begin
                c.idx = IDX_W'($urandom_range(0, route_count - 1));
            end
        end
        else
        begin
            style = $urandom_range(0, 99);
            if (route_count > 0 && style < 70)
            begin
                // Aim at a stored route, host bits random
                k      = $urandom_range(0, route_count - 1);
                c.addr = route_dest[k] | (c.addr & ~route_mask[k]);
            end
            else if (style < 85)
            begin
                c.addr = {8'($urandom_range(10, 13)), 24'($urandom)};
            end
        end
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Receiver side: random stalls, or one long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin
        m_tready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold_request)
            begin
                long_hold_request = 1'b0;
                m_tready          = 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge clk);
            end
            else
            begin
                m_tready = steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
            end
        end
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        fail_count++;
    endtask

    task automatic check_reply(input logic [OUT_DW-1:0] word);
        route_reply_t want;
        route_reply_t got;
        got.status = word[2:0];
        got.hop    = word[34:3];
        got.fill   = word[40:35];
        if (pending_replies.size() == 0)
        begin
            report_mismatch($sformatf("reply %h arrived with nothing outstanding", word));
        end
        else
        begin
            want = pending_replies.pop_front();
            if (got.status != want.status)
            begin
                report_mismatch($sformatf("reply %0d status: expected %0d, got %0d",
                                          replies_seen, want.status, got.status));
            end
            if (got.hop != want.hop)
            begin
                report_mismatch($sformatf("reply %0d next hop: expected %h, got %h",
                                          replies_seen, want.hop, got.hop));
            end
            if (got.fill != want.fill)
            begin
                report_mismatch($sformatf("reply %0d fill count: expected %0d, got %0d",
                                          replies_seen, want.fill, got.fill));
            end
        end
        replies_seen++;
    endtask

    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            check_reply(m_tdata);
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Nothing stored yet: lookups miss, deletes are refused
    task automatic test_empty_table();
        route_cmd_t c;
        lookup_route('0);
        lookup_route(ALL_ONES);
        delete_route('0);
        delete_route('1);
        // Spare opcode with every field at its top value
        c      = filler_cmd(OP_SPARE);
        c.addr = ALL_ONES;
        c.mask = ALL_ONES;
        c.dest = ALL_ONES;
        c.hop  = ALL_ONES;
        c.idx  = '1;
        send_item(c);
    endtask

    task automatic test_route_adds();
        add_route('0, '0, 32'hc0a8_0001);                    // default route
        add_route(32'hff00_0000, 32'h0a00_0000, 32'h0a00_00fe);
        add_route(32'hff00_0000, 32'h0a00_0000, 32'h0a00_00fe); // exact duplicate
        add_route(32'hff00_0000, 32'h0a00_0000, 32'h0a00_00fd); // same prefix, later
        add_route(32'hffff_ff00, 32'h0a01_0200, '0);          // directly connected
        add_route(32'hffff_0000, 32'h0a01_ffff, 32'h0000_0001); // net outside mask
        add_route(32'hff00_ff00, 32'h0a00_0200, 32'h0b0b_0b0b); // non-contiguous mask
        add_route(ALL_ONES, ALL_ONES, ALL_ONES);              // host route
    endtask

    task automatic test_route_lookups();
        lookup_route(32'h0a01_0203); // direct /24 beats the split mask
        lookup_route(32'h0a05_0207); // split mask (16 ones) beats /8
        lookup_route(32'h0a05_0507); // /8 tie, later route wins
        lookup_route(32'h0801_0101); // only the default route matches
        lookup_route(ALL_ONES);      // host route returns all ones with ok status
        lookup_route(32'h0a01_ffff); // net-outside-mask route must not match
    endtask

    task automatic test_route_deletes();
        delete_route(IDX_W'(route_count)); // one past the end
        delete_route('1);
        delete_route(5'd2);                // drop the later /8, shift the rest
        lookup_route(32'h0a05_0507);
        delete_route('0);                  // drop the default route
        lookup_route(32'h0801_0101);
    endtask

    // Fill every slot, then knock on a full table
    task automatic test_table_capacity();
        route_cmd_t c;
        while (route_count < TABLE_DEPTH)
        begin
            send_item(clustered_route());
        end
        // A duplicate on a full table reports full, not duplicate
        add_route(route_mask[0], route_dest[0], route_hop[0]);
        send_item(clustered_route());
        repeat (6)
        begin
            c      = filler_cmd(OP_LOOKUP);
            c.addr = route_dest[$urandom_range(0, TABLE_DEPTH - 1)] | (c.addr & 32'h0000_00ff);
            send_item(c);
        end
        delete_route(IDX_W'(TABLE_DEPTH - 1));
        lookup_route(ALL_ONES);
        grow_phase = 1'b0;
    endtask

    task automatic test_random_traffic(input int count);
        repeat (count)
        begin
            send_item(random_cmd());
            if (route_count >= TABLE_DEPTH)
            begin
                grow_phase = 1'b0;
            end
            else if (route_count == 0)
            begin
                grow_phase = 1'b1;
            end
        end
    endtask

    // Stall the receiver for a long stretch while items keep coming, so the
    // block holds its result and refuses new input
    task automatic test_receiver_holdoff();
        long_hold_request = 1'b1;
        test_random_traffic(24);
    endtask

    // Let everything drain, then resume from an empty pipeline
    task automatic test_sender_pause();
        settle_replies();
        test_random_traffic(300);
    endtask

    // Both sides always ready: items back to back
    task automatic test_back_to_back();
        steady = 1'b1;
        test_random_traffic(150);
        steady = 1'b0;
    endtask

    initial
    begin
        rst_n             = 1'b0;
        s_tvalid          = 1'b0;
        s_tdata           = '0;
        route_count       = 0;
        fail_count        = 0;
        replies_seen      = 0;
        steady            = 1'b0;
        long_hold_request = 1'b0;
        grow_phase        = 1'b1;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        test_empty_table();
        test_route_adds();
        test_route_lookups();
        test_route_deletes();
        test_table_capacity();
        test_random_traffic(500);
        test_receiver_holdoff();
        test_sender_pause();
        test_back_to_back();
        test_random_traffic(400);

        settle_replies();
        repeat (TABLE_DEPTH + 8) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
